>>> rtl/mirror_facet_placement_macros.svh
// assertion macros for the facet placement checker
// needs clk and rst in the scope of each use
`ifndef MIRROR_FACET_PLACEMENT_MACROS_SVH
`define MIRROR_FACET_PLACEMENT_MACROS_SVH

// same-cycle implication
`define MFP_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("facet placement check failed");

// next-cycle implication
`define MFP_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("facet placement check failed");

`endif

>>> rtl/mfp_pkg.sv
// shared types, constants and helpers for the facet placement block
// no dependencies
package mfp_pkg;

  localparam int MAX_HALF_GRID = 64;
  localparam int CNT_W = 15;
  localparam int ADDR_W = 5;

  localparam logic [30:0] SAT31 = '1;
  localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;
  localparam logic signed [31:0] MAX32 = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MIN32 = 32'sh8000_0000;

  localparam logic [2:0] REG_APERTURE = 3'd0;
  localparam logic [2:0] REG_SPACING  = 3'd1;
  localparam logic [2:0] REG_DISH     = 3'd2;
  localparam logic [2:0] REG_SHAPE    = 3'd3;
  localparam logic [2:0] REG_FOCAL    = 3'd4;
  localparam logic [2:0] REG_VERTEX_X = 3'd5;
  localparam logic [2:0] REG_VERTEX_Y = 3'd6;
  localparam logic [2:0] REG_VERTEX_Z = 3'd7;

  localparam logic OP_SQRT = 1'b0;
  localparam logic OP_DIV  = 1'b1;

  localparam logic DISH_SPHERE = 1'b0;

  typedef struct packed {
    logic signed [7:0] cell_x;
    logic signed [7:0] cell_y;
    logic              restart;
  } cell_t;

  typedef struct packed {
    logic [14:0]        facet_number;
    logic signed [31:0] centre_x;
    logic signed [31:0] centre_y;
    logic signed [31:0] centre_z;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic [30:0]        curvature_radius;
  } facet_t;

  typedef struct packed {
    logic [30:0]        aperture_radius;
    logic [30:0]        grid_spacing;
    logic               dish_type;
    logic [30:0]        shape_length;
    logic [30:0]        focal_length;
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic signed [31:0] vertex_z;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic op;
  } unit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v[35:31] != {5{v[35]}}) begin
      r = v[35] ? MIN32 : MAX32;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/mfp_cfg.sv
// configuration register file behind the apb-style port
// depends on mfp_pkg
module mfp_cfg
  import mfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output cfg_t              cfg
);

  logic       wr;
  logic [2:0] idx;

  assign wr  = psel && penable && pwrite;
  assign idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.aperture_radius <= '0;
      cfg.grid_spacing    <= 31'd65536;
      cfg.dish_type       <= DISH_SPHERE;
      cfg.shape_length    <= '0;
      cfg.focal_length    <= '0;
      cfg.vertex_x        <= '0;
      cfg.vertex_y        <= '0;
      cfg.vertex_z        <= '0;
    end else if (wr) begin
      case (idx)
        REG_APERTURE: cfg.aperture_radius <= pwdata[30:0];
        REG_SPACING:  cfg.grid_spacing    <= pwdata[30:0];
        REG_DISH:     cfg.dish_type       <= pwdata[0];
        REG_SHAPE:    cfg.shape_length    <= pwdata[30:0];
        REG_FOCAL:    cfg.focal_length    <= pwdata[30:0];
        REG_VERTEX_X: cfg.vertex_x        <= pwdata;
        REG_VERTEX_Y: cfg.vertex_y        <= pwdata;
        REG_VERTEX_Z: cfg.vertex_z        <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_APERTURE: prdata = {1'b0, cfg.aperture_radius};
      REG_SPACING:  prdata = {1'b0, cfg.grid_spacing};
      REG_DISH:     prdata = {31'b0, cfg.dish_type};
      REG_SHAPE:    prdata = {1'b0, cfg.shape_length};
      REG_FOCAL:    prdata = {1'b0, cfg.focal_length};
      REG_VERTEX_X: prdata = cfg.vertex_x;
      REG_VERTEX_Y: prdata = cfg.vertex_y;
      REG_VERTEX_Z: prdata = cfg.vertex_z;
      default:      prdata = '0;
    endcase
  end

endmodule

>>> rtl/mfp_sqdiv.sv
// shared bit-serial unit: 64-bit integer square root or 64/34-bit division
// depends on mfp_pkg
module mfp_sqdiv
  import mfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  unit_req_t   req,
  input  logic [63:0] a,
  input  logic [33:0] b,
  output unit_sts_t   sts,
  output logic [63:0] res
);

  logic        busy;
  logic        done;
  logic        op;
  logic [5:0]  cnt;
  logic [63:0] n;
  logic [63:0] r;
  logic [63:0] bit_w;
  logic [33:0] dvs;
  logic [33:0] rem;
  logic [63:0] q;

  logic [64:0] trial;
  logic [34:0] shifted;
  logic        sq_ok;
  logic        dv_ok;

  assign trial   = {1'b0, r} + {1'b0, bit_w};
  assign sq_ok   = {1'b0, n} >= trial;
  assign shifted = {rem, n[63]};
  assign dv_ok   = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        op   <= req.op;
        n    <= a;
        r    <= '0;
        q    <= '0;
        rem  <= '0;
        dvs  <= b;
        bit_w <= 64'h4000_0000_0000_0000;
        cnt  <= (req.op == OP_DIV) ? 6'd63 : 6'd31;
      end else if (busy) begin
        if (op == OP_DIV) begin
          n <= {n[62:0], 1'b0};
          if (dv_ok) begin
            rem <= 34'(shifted - {1'b0, dvs});
            q   <= {q[62:0], 1'b1};
          end else begin
            rem <= shifted[33:0];
            q   <= {q[62:0], 1'b0};
          end
        end else begin
          if (sq_ok) begin
            n <= n - trial[63:0];
            r <= (r >> 1) + bit_w;
          end else begin
            r <= r >> 1;
          end
          bit_w <= bit_w >> 2;
        end
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 6'd1;
        end
      end
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
  assign res      = (op == OP_DIV) ? q : r;

endmodule

>>> rtl/mirror_facet_placement.sv
// facet placement top level: config port, sequencer, multiplier, output register
// depends on mfp_pkg, mfp_cfg, mfp_sqdiv
//
//   channel | valid       | stall       | payload
//   cell    | cell_valid  | cell_stall  | grid_cell (cell_t)
//   facet   | facet_valid | facet_stall | facet (facet_t)
//   config  | psel/penable/pwrite, pready tied high | paddr, pwdata, prdata
//
// one request at a time; a rejected cell yields no facet
// an accepted cell runs through the sequencer up to its facet register load; the shared
// root/divide unit works one bit per cycle, 32 steps per root, 64 per quotient
// a facet held off at the output holds the sequencer in its last state
// cell_stall is high while a request is in work
// synchronous reset clears the sequencer, facet count and output valid
module mirror_facet_placement
  import mfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cell_valid,
  output logic              cell_stall,
  input  cell_t             grid_cell,
  output logic              facet_valid,
  input  logic              facet_stall,
  output facet_t            facet,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_AX_W     = 5'd1;
  localparam logic [4:0] S_AX_U     = 5'd2;
  localparam logic [4:0] S_AY_W     = 5'd3;
  localparam logic [4:0] S_AY_U     = 5'd4;
  localparam logic [4:0] S_CHK      = 5'd5;
  localparam logic [4:0] S_R2A_W    = 5'd6;
  localparam logic [4:0] S_R2A_U    = 5'd7;
  localparam logic [4:0] S_R2B_W    = 5'd8;
  localparam logic [4:0] S_R2B_U    = 5'd9;
  localparam logic [4:0] S_AR_W     = 5'd10;
  localparam logic [4:0] S_AR_U     = 5'd11;
  localparam logic [4:0] S_LEN_W    = 5'd12;
  localparam logic [4:0] S_LEN_U    = 5'd13;
  localparam logic [4:0] S_CZ_WAIT  = 5'd14;
  localparam logic [4:0] S_DVEC     = 5'd15;
  localparam logic [4:0] S_M0_W     = 5'd16;
  localparam logic [4:0] S_M0_U     = 5'd17;
  localparam logic [4:0] S_M1_W     = 5'd18;
  localparam logic [4:0] S_M1_U     = 5'd19;
  localparam logic [4:0] S_M2_W     = 5'd20;
  localparam logic [4:0] S_M2_U     = 5'd21;
  localparam logic [4:0] S_CURV_WAIT = 5'd22;
  localparam logic [4:0] S_L_START  = 5'd23;
  localparam logic [4:0] S_L_WAIT   = 5'd24;
  localparam logic [4:0] S_W2_W     = 5'd25;
  localparam logic [4:0] S_W2_U     = 5'd26;
  localparam logic [4:0] S_WL_WAIT  = 5'd27;
  localparam logic [4:0] S_N_START  = 5'd28;
  localparam logic [4:0] S_N_WAIT   = 5'd29;
  localparam logic [4:0] S_OUT      = 5'd30;

  cfg_t cfg;

  mfp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  assign pready = 1'b1;

  // shared root / divide unit
  logic        u_start;
  logic        u_op;
  logic [63:0] u_a;
  logic [33:0] u_b;
  unit_req_t   u_req;
  unit_sts_t   u_sts;
  logic [63:0] u_res;

  assign u_req.start = u_start;
  assign u_req.op    = u_op;

  mfp_sqdiv u_unit (
    .clk (clk),
    .rst (rst),
    .req (u_req),
    .a   (u_a),
    .b   (u_b),
    .sts (u_sts),
    .res (u_res)
  );

  // shared multiplier
  logic [31:0] ma;
  logic [31:0] mb;
  logic [63:0] prod;

  always_ff @(posedge clk) begin
    prod <= 64'(ma) * 64'(mb);
  end

  logic [4:0]         state;
  logic [CNT_W-1:0]   count;
  logic               out_valid;
  facet_t             out_reg;

  logic               sx;
  logic               sy;
  logic [6:0]         gx;
  logic [6:0]         gy;
  logic [37:0]        ax;
  logic [37:0]        ay;
  logic [63:0]        r2;
  logic [63:0]        acc;
  logic [63:0]        sum;
  logic signed [31:0] cx;
  logic signed [31:0] cy;
  logic signed [31:0] cz;
  logic signed [33:0] fz;
  logic [29:0]        m0;
  logic [29:0]        m1;
  logic [29:0]        m2;
  logic [2:0]         neg;
  logic               big;
  logic [30:0]        curv;
  logic               w2_neg;
  logic [31:0]        mw2;
  logic [31:0]        wl;
  logic [1:0]         nidx;
  logic signed [31:0] nrm [3];

  logic        accept;
  logic [7:0]  mag_x;
  logic [7:0]  mag_y;
  logic [32:0] x33;
  logic [32:0] y33;
  logic signed [34:0] d0;
  logic signed [34:0] d1;
  logic signed [34:0] d2;
  logic [34:0] md0;
  logic [34:0] md1;
  logic [34:0] md2;
  logic [34:0] dmax;
  logic [2:0]  shamt;
  logic [63:0] sum_c;
  logic [32:0] w2;
  logic [31:0] nmag;
  logic [63:0] qclip;
  logic [31:0] qn;

  assign accept     = cell_valid && !cell_stall;
  assign cell_stall = (state != S_IDLE);
  assign mag_x      = grid_cell.cell_x[7] ? 8'(-grid_cell.cell_x) : grid_cell.cell_x;
  assign mag_y      = grid_cell.cell_y[7] ? 8'(-grid_cell.cell_y) : grid_cell.cell_y;

  assign x33 = sx ? 33'(-{2'b0, ax[30:0]}) : {2'b0, ax[30:0]};
  assign y33 = sy ? 33'(-{2'b0, ay[30:0]}) : {2'b0, ay[30:0]};

  assign d0  = {{3{cfg.vertex_x[31]}}, cfg.vertex_x} - {{3{cx[31]}}, cx};
  assign d1  = {{3{cfg.vertex_y[31]}}, cfg.vertex_y} - {{3{cy[31]}}, cy};
  assign d2  = {fz[33], fz} - {{3{cz[31]}}, cz};
  assign md0 = d0[34] ? 35'(-d0) : d0;
  assign md1 = d1[34] ? 35'(-d1) : d1;
  assign md2 = d2[34] ? 35'(-d2) : d2;

  always_comb begin
    dmax = md0;
    if (md1 > dmax) begin
      dmax = md1;
    end
    if (md2 > dmax) begin
      dmax = md2;
    end
    if (dmax[34:33] != 2'b0) begin
      shamt = 3'd4;
    end else if (dmax[32]) begin
      shamt = 3'd3;
    end else if (dmax[31]) begin
      shamt = 3'd2;
    end else if (dmax[30]) begin
      shamt = 3'd1;
    end else begin
      shamt = 3'd0;
    end
  end

  assign sum_c = acc + prod;
  assign w2    = (neg[2] ? 33'(-{3'b0, m2}) : {3'b0, m2}) + {1'b0, u_res[31:0]};

  always_comb begin
    case (nidx)
      2'd0:    nmag = {2'b0, m0};
      2'd1:    nmag = {2'b0, m1};
      default: nmag = mw2;
    endcase
  end

  assign qclip = (u_res > 64'h4000_0000) ? 64'h4000_0000 : u_res;
  assign qn    = qclip[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      u_start   <= 1'b0;
    end else begin
      u_start <= 1'b0;
      if (out_valid && !facet_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (grid_cell.restart) begin
              count <= '0;
            end
            sx <= grid_cell.cell_x[7];
            sy <= grid_cell.cell_y[7];
            gx <= mag_x[6:0];
            gy <= mag_y[6:0];
            ma <= {24'b0, mag_x};
            mb <= {1'b0, cfg.grid_spacing};
            if (mag_x <= 8'(MAX_HALF_GRID) && mag_y <= 8'(MAX_HALF_GRID)) begin
              state <= S_AX_W;
            end
          end
        end
        S_AX_W: state <= S_AX_U;
        S_AX_U: begin
          ax    <= prod[37:0];
          ma    <= {25'b0, gy};
          state <= S_AY_W;
        end
        S_AY_W: state <= S_AY_U;
        S_AY_U: begin
          ay    <= prod[37:0];
          state <= S_CHK;
        end
        S_CHK: begin
          if (ax > {7'b0, cfg.aperture_radius} || ay > {7'b0, cfg.aperture_radius}) begin
            state <= S_IDLE;
          end else begin
            ma    <= {1'b0, ax[30:0]};
            mb    <= {1'b0, ax[30:0]};
            state <= S_R2A_W;
          end
        end
        S_R2A_W: state <= S_R2A_U;
        S_R2A_U: begin
          acc   <= prod;
          ma    <= {1'b0, ay[30:0]};
          mb    <= {1'b0, ay[30:0]};
          state <= S_R2B_W;
        end
        S_R2B_W: state <= S_R2B_U;
        S_R2B_U: begin
          r2    <= sum_c;
          ma    <= {1'b0, cfg.aperture_radius};
          mb    <= {1'b0, cfg.aperture_radius};
          state <= S_AR_W;
        end
        S_AR_W: state <= S_AR_U;
        S_AR_U: begin
          if (r2 > prod) begin
            state <= S_IDLE;
          end else begin
            cx <= sat32({{4{cfg.vertex_x[31]}}, cfg.vertex_x} + {{3{x33[32]}}, x33});
            cy <= sat32({{4{cfg.vertex_y[31]}}, cfg.vertex_y} + {{3{y33[32]}}, y33});
            fz <= {{2{cfg.vertex_z[31]}}, cfg.vertex_z} + {3'b0, cfg.focal_length};
            ma <= {1'b0, cfg.shape_length};
            mb <= {1'b0, cfg.shape_length};
            if (cfg.focal_length[30]) begin
              curv <= SAT31;
            end else begin
              curv <= {cfg.focal_length[29:0], 1'b0};
            end
            state <= S_LEN_W;
          end
        end
        S_LEN_W: state <= S_LEN_U;
        S_LEN_U: begin
          if (cfg.dish_type == DISH_SPHERE) begin
            if (r2 < prod) begin
              u_start <= 1'b1;
              u_op    <= OP_SQRT;
              u_a     <= prod - r2;
              state   <= S_CZ_WAIT;
            end else begin
              cz    <= cfg.vertex_z;
              state <= S_DVEC;
            end
          end else begin
            if (cfg.shape_length != '0) begin
              u_start <= 1'b1;
              u_op    <= OP_DIV;
              u_a     <= r2;
              u_b     <= {1'b0, cfg.shape_length, 2'b00};
              state   <= S_CZ_WAIT;
            end else begin
              cz    <= cfg.vertex_z;
              state <= S_DVEC;
            end
          end
        end
        S_CZ_WAIT: begin
          if (u_sts.done) begin
            if (cfg.dish_type == DISH_SPHERE) begin
              cz <= sat32({{2{fz[33]}}, fz} - {4'b0, u_res[31:0]});
            end else if (u_res > 64'h2_0000_0000) begin
              cz <= sat32({{4{cfg.vertex_z[31]}}, cfg.vertex_z} + 36'h2_0000_0000);
            end else begin
              cz <= sat32({{4{cfg.vertex_z[31]}}, cfg.vertex_z} + {2'b0, u_res[33:0]});
            end
            state <= S_DVEC;
          end
        end
        S_DVEC: begin
          m0    <= 30'(md0 >> shamt);
          m1    <= 30'(md1 >> shamt);
          m2    <= 30'(md2 >> shamt);
          ma    <= {2'b0, 30'(md0 >> shamt)};
          mb    <= {2'b0, 30'(md0 >> shamt)};
          neg   <= {d2[34], d1[34], d0[34]};
          big   <= shamt != 3'd0;
          state <= S_M0_W;
        end
        S_M0_W: state <= S_M0_U;
        S_M0_U: begin
          acc   <= prod;
          ma    <= {2'b0, m1};
          mb    <= {2'b0, m1};
          state <= S_M1_W;
        end
        S_M1_W: state <= S_M1_U;
        S_M1_U: begin
          acc   <= sum_c;
          ma    <= {2'b0, m2};
          mb    <= {2'b0, m2};
          state <= S_M2_W;
        end
        S_M2_W: state <= S_M2_U;
        S_M2_U: begin
          sum <= sum_c;
          if (cfg.dish_type != DISH_SPHERE) begin
            if (big) begin
              curv  <= SAT31;
              state <= S_L_START;
            end else begin
              u_start <= 1'b1;
              u_op    <= OP_SQRT;
              u_a     <= {sum_c[61:0], 2'b00};
              state   <= S_CURV_WAIT;
            end
          end else begin
            state <= S_L_START;
          end
        end
        S_CURV_WAIT: begin
          if (u_sts.done) begin
            curv  <= (u_res[63:31] != '0) ? SAT31 : u_res[30:0];
            state <= S_L_START;
          end
        end
        S_L_START: begin
          nrm[0] <= '0;
          nrm[1] <= '0;
          nrm[2] <= ONE_Q30;
          if (cfg.shape_length == '0) begin
            state <= S_OUT;
          end else begin
            u_start <= 1'b1;
            u_op    <= OP_SQRT;
            u_a     <= sum;
            state   <= S_L_WAIT;
          end
        end
        S_L_WAIT: begin
          if (u_sts.done) begin
            if (u_res == '0) begin
              state <= S_OUT;
            end else begin
              w2_neg <= w2[32];
              mw2    <= w2[32] ? 32'(-w2) : w2[31:0];
              ma     <= w2[32] ? 32'(-w2) : w2[31:0];
              mb     <= w2[32] ? 32'(-w2) : w2[31:0];
              state  <= S_W2_W;
            end
          end
        end
        S_W2_W: state <= S_W2_U;
        S_W2_U: begin
          u_start <= 1'b1;
          u_op    <= OP_SQRT;
          u_a     <= sum_c;
          state   <= S_WL_WAIT;
        end
        S_WL_WAIT: begin
          if (u_sts.done) begin
            if (u_res == '0) begin
              state <= S_OUT;
            end else begin
              wl    <= u_res[31:0];
              nidx  <= 2'd0;
              state <= S_N_START;
            end
          end
        end
        S_N_START: begin
          u_start <= 1'b1;
          u_op    <= OP_DIV;
          u_a     <= {2'b0, nmag, 30'b0};
          u_b     <= {2'b0, wl};
          state   <= S_N_WAIT;
        end
        S_N_WAIT: begin
          if (u_sts.done) begin
            case (nidx)
              2'd0:    nrm[0] <= neg[0] ? 32'(-qn) : qn;
              2'd1:    nrm[1] <= neg[1] ? 32'(-qn) : qn;
              default: nrm[2] <= w2_neg ? 32'(-qn) : qn;
            endcase
            if (nidx == 2'd2) begin
              state <= S_OUT;
            end else begin
              nidx  <= nidx + 2'd1;
              state <= S_N_START;
            end
          end
        end
        S_OUT: begin
          if (!out_valid || !facet_stall) begin
            out_reg.facet_number     <= count;
            out_reg.centre_x         <= cx;
            out_reg.centre_y         <= cy;
            out_reg.centre_z         <= cz;
            out_reg.normal_x         <= nrm[0];
            out_reg.normal_y         <= nrm[1];
            out_reg.normal_z         <= nrm[2];
            out_reg.curvature_radius <= curv;
            out_valid <= 1'b1;
            count     <= count + 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign facet_valid = out_valid;
  assign facet       = out_reg;

endmodule

>>> rtl/mfp_checker.sv
// port-level checker for the facet placement block, bound to the top level
// depends on mfp_pkg and mirror_facet_placement_macros.svh
`include "mirror_facet_placement_macros.svh"

module mfp_checker
  import mfp_pkg::*;
(
  input logic   clk,
  input logic   rst,
  input logic   cell_valid,
  input logic   cell_stall,
  input logic   facet_valid,
  input logic   facet_stall,
  input facet_t facet
);

  `MFP_NEXT(a_facet_hold, facet_valid && facet_stall, facet_valid && $stable(facet))
  `MFP_NEXT(a_no_instant_facet, cell_valid && !cell_stall && !facet_valid, !facet_valid)
  `MFP_NOW(a_normal_z_unit, facet_valid, (facet.normal_z <= ONE_Q30) && (facet.normal_z >= -ONE_Q30))

endmodule

bind mirror_facet_placement mfp_checker u_mfp_checker (
  .clk         (clk),
  .rst         (rst),
  .cell_valid  (cell_valid),
  .cell_stall  (cell_stall),
  .facet_valid (facet_valid),
  .facet_stall (facet_stall),
  .facet       (facet)
);
